/* design/dpwp_pkg.sv */
// Shared types, codes and reset constants for the depth pixel to world point block.
// Used by dpwp_ctrl, dpwp_datapath and depth_pixel_to_world_point; depends on nothing.
`default_nettype none

package dpwp_pkg;

  localparam int MAX_AREAS_DEF  = 16;
  localparam int COORD_BITS_DEF = 12;
  localparam int POSE_COEFS     = 12;
  localparam int LAST_OP        = 12;

  localparam logic [1:0] ACT_PIXEL = 2'd0;
  localparam logic [1:0] ACT_RECT  = 2'd1;
  localparam logic [1:0] ACT_POSE  = 2'd2;

  localparam logic [2:0] CFG_INV_FOCAL_X = 3'd0;
  localparam logic [2:0] CFG_INV_FOCAL_Y = 3'd1;
  localparam logic [2:0] CFG_CENTER_X    = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y    = 3'd3;
  localparam logic [2:0] CFG_DEPTH_MIN   = 3'd4;
  localparam logic [2:0] CFG_DEPTH_MAX   = 3'd5;
  localparam logic [2:0] CFG_AREA_COUNT  = 3'd6;

  localparam logic [23:0] RST_INV_FOCAL = 24'd32768;
  localparam logic [15:0] RST_CENTER_X  = 16'd5120;
  localparam logic [15:0] RST_CENTER_Y  = 16'd3840;
  localparam logic [15:0] RST_DEPTH_MIN = 16'd10;
  localparam logic [15:0] RST_DEPTH_MAX = 16'd10000;
  localparam logic signed [31:0] POSE_ONE = 32'sd65536;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        pixel_col;
    logic [11:0]        pixel_row;
    logic [15:0]        depth_mm;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [3:0]         slot;
    logic signed [31:0] coef_value;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [7:0]         point_red;
    logic [7:0]         point_green;
    logic [7:0]         point_blue;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_DEPTH_X,
    OP_DEPTH_Y,
    OP_FOCAL_X,
    OP_FOCAL_Y,
    OP_POSE
  } op_t;

  typedef struct packed {
    logic       load;
    logic       scan_step;
    logic       mul;
    logic       acc;
    logic       emit;
    op_t        op;
    logic [1:0] row;
    logic [1:0] col;
  } cmd_t;

  typedef struct packed {
    logic depth_ok;
    logic no_areas;
    logic hit;
    logic scan_last;
  } status_t;

endpackage

`default_nettype wire

/* design/depth_pixel_to_world_point.sv */
// Top level of the depth pixel to world point block: controller plus datapath.
// Depends on dpwp_pkg, dpwp_ctrl and dpwp_datapath.
//
// Each input beat is a depth pixel, a dynamic-area rectangle load (slot, left/top from the
// pixel position, width and height) or one pose coefficient load (slot 0..11, row-major,
// signed Q16.16, already the camera-to-world transform). Loads take effect in the cycle they
// are accepted and produce no output. A pixel inside one of the first area_count rectangles,
// or with depth outside [depth_min, depth_max], produces no output; otherwise it is
// back-projected through the pinhole intrinsics, rotated and translated by the pose, and one
// beat with the saturated Q16.16 world point in millimetres and the pixel colour follows.
// Items are processed one at a time through a single shared multiplier: a load or a
// depth-rejected pixel is finished in the cycle it is accepted, and a pixel that lands in a
// rectangle goes through a fetch state and scans the rectangles up to the one that matched.
// An accepted pixel goes straight to the multiply steps when no rectangles are checked;
// otherwise all enabled rectangles are first scanned (one per cycle through the registered
// read port of the rectangle store, after a fetch state). Then come thirteen multiply and
// accumulate steps, each a multiply state and then an accumulate state, and the step that
// loads the output register, which stretches while the previous point still waits there.
// A finished point waits in the output register, so the next item is taken while it is
// still waiting. Rectangles must be loaded before they are enabled by area_count.
// Configuration writes are always ready and must be issued only while the block is idle.
`default_nettype none

module depth_pixel_to_world_point #(
  parameter int MAX_AREAS  = dpwp_pkg::MAX_AREAS_DEF,
  parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dpwp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dpwp_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [23:0]         cfg_data
);
  import dpwp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Registers can be written in any cycle.
  assign cfg_ready = 1'b1;

  dpwp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dpwp_datapath #(
    .MAX_AREAS  (MAX_AREAS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* design/dpwp_ctrl.sv */
// Controller state machine: sequences the rectangle scan and the multiply steps.
// Depends on dpwp_pkg; drives dpwp_datapath through cmd_t and reads status_t.
`default_nettype none

module dpwp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_action,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire dpwp_pkg::status_t status,
  output dpwp_pkg::cmd_t        cmd
);
  import dpwp_pkg::*;

  state_t     state, state_next;
  logic [3:0] op_idx;
  logic [1:0] row, col;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_PIXEL && status.depth_ok) begin
          state_next = status.no_areas ? ST_MUL : ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.hit) begin
          state_next = ST_IDLE;
        end else if (status.scan_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_ACC;
      ST_ACC: begin
        state_next = (op_idx == 4'(LAST_OP)) ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd.load      = in_valid && (state == ST_IDLE);
    cmd.scan_step = (state == ST_FETCH) || (state == ST_SCAN);
    cmd.mul       = (state == ST_MUL);
    cmd.acc       = (state == ST_ACC);
    cmd.emit      = (state == ST_EMIT) && out_free;
    cmd.row       = row;
    cmd.col       = col;
    case (op_idx)
      4'd0:    cmd.op = OP_DEPTH_X;
      4'd1:    cmd.op = OP_DEPTH_Y;
      4'd2:    cmd.op = OP_FOCAL_X;
      4'd3:    cmd.op = OP_FOCAL_Y;
      default: cmd.op = OP_POSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op_idx    <= '0;
      row       <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        op_idx <= '0;
        row    <= '0;
        col    <= '0;
      end else if (cmd.acc) begin
        op_idx <= op_idx + 4'd1;
        if (cmd.op == OP_POSE) begin
          if (col == 2'd2) begin
            col <= '0;
            row <= row + 2'd1;
          end else begin
            col <= col + 2'd1;
          end
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/dpwp_datapath.sv */
// Datapath: configuration registers, rectangle store, pose, shared multiplier, output register.
// Depends on dpwp_pkg; commanded by dpwp_ctrl.
`default_nettype none

module dpwp_datapath #(
  parameter int MAX_AREAS  = dpwp_pkg::MAX_AREAS_DEF,
  parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dpwp_pkg::in_item_t in_data,
  input  wire logic               cfg_valid,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire dpwp_pkg::cmd_t     cmd,
  output dpwp_pkg::status_t       status,
  output dpwp_pkg::out_item_t     out_data
);
  import dpwp_pkg::*;

  localparam int CW = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam int AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int NW = $clog2(MAX_AREAS + 1);

  localparam logic signed [67:0] CAM_MAX = 68'sd4294967295;
  localparam logic signed [67:0] CAM_MIN = -68'sd4294967295;
  localparam logic signed [67:0] W_MAX   = 68'sd2147483647;
  localparam logic signed [67:0] W_MIN   = -68'sd2147483648;

  logic [23:0] inv_focal_x, inv_focal_y;
  logic [15:0] center_x, center_y, depth_min, depth_max;
  logic [4:0]  area_count;

  logic signed [31:0] pose [POSE_COEFS];
  logic [4*CW-1:0]    boxes [MAX_AREAS];
  logic [4*CW-1:0]    box_q;
  logic [AW-1:0]      rd_idx, cur_idx;
  logic [AW+3:0]      slot_wide;
  logic [NW-1:0]      n_areas;

  logic [CW-1:0] col_q, row_q;
  logic [15:0]   depth_q;
  logic [7:0]    red_q, green_q, blue_q;

  logic signed [34:0] tx, ty;
  logic signed [32:0] cam_x, cam_y, cam_z, cam_sel;
  logic signed [67:0] prod, acc, sum, cam_t, world_t;
  logic signed [34:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [17:0] dx, dy;
  logic [3:0]         pose_addr;
  logic signed [31:0] pose_rd;
  logic signed [31:0] wx, wy, wz, w_sat;
  logic [CW:0]        left, top, width, height;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_focal_x <= RST_INV_FOCAL;
      inv_focal_y <= RST_INV_FOCAL;
      center_x    <= RST_CENTER_X;
      center_y    <= RST_CENTER_Y;
      depth_min   <= RST_DEPTH_MIN;
      depth_max   <= RST_DEPTH_MAX;
      area_count  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INV_FOCAL_X: inv_focal_x <= cfg_data;
        CFG_INV_FOCAL_Y: inv_focal_y <= cfg_data;
        CFG_CENTER_X:    center_x    <= cfg_data[15:0];
        CFG_CENTER_Y:    center_y    <= cfg_data[15:0];
        CFG_DEPTH_MIN:   depth_min   <= cfg_data[15:0];
        CFG_DEPTH_MAX:   depth_max   <= cfg_data[15:0];
        CFG_AREA_COUNT:  area_count  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Pose matrix, reset to identity.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POSE_COEFS; i++) begin
        pose[i] <= (i == 0 || i == 5 || i == 10) ? POSE_ONE : 32'sd0;
      end
    end else if (cmd.load && in_data.action == ACT_POSE && int'(in_data.slot) < POSE_COEFS) begin
      pose[in_data.slot] <= in_data.coef_value;
    end
  end

  // Rectangle store: one write port, one registered read port.
  assign slot_wide = (AW + 4)'(in_data.slot);

  always_ff @(posedge clk) begin
    if (cmd.load && in_data.action == ACT_RECT && int'(in_data.slot) < MAX_AREAS) begin
      boxes[slot_wide[AW-1:0]] <= {in_data.pixel_col[CW-1:0], in_data.pixel_row[CW-1:0],
                                   in_data.rect_width[CW-1:0], in_data.rect_height[CW-1:0]};
    end
    if (cmd.scan_step) begin
      box_q <= boxes[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      cur_idx <= '0;
    end else if (cmd.load) begin
      rd_idx <= '0;
    end else if (cmd.scan_step) begin
      rd_idx  <= rd_idx + AW'(1);
      cur_idx <= rd_idx;
    end
  end

  always_comb begin
    if (int'(area_count) > MAX_AREAS) begin
      n_areas = NW'(MAX_AREAS);
    end else begin
      n_areas = NW'(area_count);
    end
  end

  assign left   = {1'b0, box_q[4*CW-1:3*CW]};
  assign top    = {1'b0, box_q[3*CW-1:2*CW]};
  assign width  = {1'b0, box_q[2*CW-1:CW]};
  assign height = {1'b0, box_q[CW-1:0]};

  always_comb begin
    status.depth_ok  = (in_data.depth_mm >= depth_min) && (in_data.depth_mm <= depth_max);
    status.no_areas  = (n_areas == '0);
    status.hit       = ({1'b0, col_q} >= left) && ({1'b0, col_q} < left + width) &&
                       ({1'b0, row_q} >= top) && ({1'b0, row_q} < top + height);
    status.scan_last = (NW'(cur_idx) + NW'(1)) == n_areas;
  end

  // Pixel capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q   <= in_data.pixel_col[CW-1:0];
      row_q   <= in_data.pixel_row[CW-1:0];
      depth_q <= in_data.depth_mm;
      red_q   <= in_data.red;
      green_q <= in_data.green;
      blue_q  <= in_data.blue;
    end
  end

  // Offsets from the principal point, Q.4.
  assign dx    = $signed({2'b00, 12'(col_q), 4'b0000}) - $signed({2'b00, center_x});
  assign dy    = $signed({2'b00, 12'(row_q), 4'b0000}) - $signed({2'b00, center_y});
  assign cam_z = $signed({1'b0, depth_q, 16'h0000});

  assign pose_addr = cmd.acc ? {cmd.row, 2'b11} : {cmd.row, cmd.col};
  assign pose_rd   = pose[pose_addr];

  always_comb begin
    case (cmd.col)
      2'd0:    cam_sel = cam_x;
      2'd1:    cam_sel = cam_y;
      default: cam_sel = cam_z;
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_DEPTH_X: begin
        mul_a = 35'(dx);
        mul_b = $signed({17'd0, depth_q});
      end
      OP_DEPTH_Y: begin
        mul_a = 35'(dy);
        mul_b = $signed({17'd0, depth_q});
      end
      OP_FOCAL_X: begin
        mul_a = tx;
        mul_b = $signed({9'd0, inv_focal_x});
      end
      OP_FOCAL_Y: begin
        mul_a = ty;
        mul_b = $signed({9'd0, inv_focal_y});
      end
      default: begin
        mul_a = 35'(pose_rd);
        mul_b = cam_sel;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= 68'(mul_a) * 68'(mul_b);
    end
  end

  assign cam_t   = (prod + 68'sd2048) >>> 12;
  assign sum     = (cmd.col == 2'd0) ? prod : acc + prod;
  assign world_t = ((sum + 68'sd32768) >>> 16) + 68'(pose_rd);

  always_comb begin
    if (world_t > W_MAX) begin
      w_sat = 32'sh7FFFFFFF;
    end else if (world_t < W_MIN) begin
      w_sat = 32'sh80000000;
    end else begin
      w_sat = world_t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      case (cmd.op)
        OP_DEPTH_X: tx <= prod[34:0];
        OP_DEPTH_Y: ty <= prod[34:0];
        OP_FOCAL_X: begin
          if (cam_t > CAM_MAX)      cam_x <= CAM_MAX[32:0];
          else if (cam_t < CAM_MIN) cam_x <= CAM_MIN[32:0];
          else                      cam_x <= cam_t[32:0];
        end
        OP_FOCAL_Y: begin
          if (cam_t > CAM_MAX)      cam_y <= CAM_MAX[32:0];
          else if (cam_t < CAM_MIN) cam_y <= CAM_MIN[32:0];
          else                      cam_y <= cam_t[32:0];
        end
        default: begin
          acc <= sum;
          if (cmd.col == 2'd2) begin
            case (cmd.row)
              2'd0:    wx <= w_sat;
              2'd1:    wy <= w_sat;
              default: wz <= w_sat;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= '{world_x: wx, world_y: wy, world_z: wz,
                    point_red: red_q, point_green: green_q, point_blue: blue_q};
    end
  end

endmodule

`default_nettype wire
